>>> rtl/core/hpq_pkg.sv
// ----------------------------------------------------------------------------
// hpq_pkg
// Shared types, codes and constants of the max-heap priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package hpq_pkg;

	localparam int DEFAULT_CAPACITY = 256;

	// request operation codes
	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// datapath operation codes
	localparam logic [3:0] OP_IDLE     = 4'd0;
	localparam logic [3:0] OP_LOAD     = 4'd1;
	localparam logic [3:0] OP_REJECT   = 4'd2;
	localparam logic [3:0] OP_INC      = 4'd3;
	localparam logic [3:0] OP_PLACE    = 4'd4;
	localparam logic [3:0] OP_UP_RD    = 4'd5;
	localparam logic [3:0] OP_UP_MOVE  = 4'd6;
	localparam logic [3:0] OP_POP_RD   = 4'd7;
	localparam logic [3:0] OP_POP_TAKE = 4'd8;
	localparam logic [3:0] OP_DN_RD    = 4'd9;
	localparam logic [3:0] OP_DN_MOVE  = 4'd10;
	localparam logic [3:0] OP_TOP_RD   = 4'd11;
	localparam logic [3:0] OP_FINISH   = 4'd12;

	typedef struct packed {
		logic               func;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] popped_value;
		logic signed [31:0] top_value;
		logic [8:0]         count;
	} rsp_t;

	typedef struct packed {
		logic [3:0] op;
	} cmd_t;

	typedef struct packed {
		logic is_pop;    // latched request is a pop
		logic reject;    // pop on empty or push on full
		logic at_root;   // hole is at the root
		logic has_left;  // hole has at least a left child
		logic swap;      // compare says move the neighbor into the hole
	} stat_t;

endpackage

`default_nettype wire

>>> rtl/core/hpq_ctrl.sv
// ----------------------------------------------------------------------------
// hpq_ctrl
// Sequencer for push/pop: sift-up and sift-down loops, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module hpq_ctrl
	import hpq_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  req_valid,
	output logic       req_ready,
	output logic       rsp_valid,
	input  wire logic  rsp_ready,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_CHECK    = 4'd1;
	localparam logic [3:0] S_UP       = 4'd2;
	localparam logic [3:0] S_UP_CMP   = 4'd3;
	localparam logic [3:0] S_POP_TAKE = 4'd4;
	localparam logic [3:0] S_DOWN     = 4'd5;
	localparam logic [3:0] S_DN_CMP   = 4'd6;
	localparam logic [3:0] S_TOP      = 4'd7;
	localparam logic [3:0] S_FIN      = 4'd8;

	logic [3:0] state_q, state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd.op  = OP_IDLE;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.reject) begin
					cmd.op  = OP_REJECT;
					state_d = S_TOP;
				end else if (stat.is_pop) begin
					cmd.op  = OP_POP_RD;
					state_d = S_POP_TAKE;
				end else begin
					cmd.op  = OP_INC;
					state_d = S_UP;
				end
			end
			S_UP: begin
				if (stat.at_root) begin
					cmd.op  = OP_PLACE;
					state_d = S_TOP;
				end else begin
					cmd.op  = OP_UP_RD;
					state_d = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (stat.swap) begin
					cmd.op  = OP_UP_MOVE;
					state_d = S_UP;
				end else begin
					cmd.op  = OP_PLACE;
					state_d = S_TOP;
				end
			end
			S_POP_TAKE: begin
				cmd.op  = OP_POP_TAKE;
				state_d = S_DOWN;
			end
			S_DOWN: begin
				if (stat.has_left) begin
					cmd.op  = OP_DN_RD;
					state_d = S_DN_CMP;
				end else begin
					cmd.op  = OP_PLACE;
					state_d = S_TOP;
				end
			end
			S_DN_CMP: begin
				if (stat.swap) begin
					cmd.op  = OP_DN_MOVE;
					state_d = S_DOWN;
				end else begin
					cmd.op  = OP_PLACE;
					state_d = S_TOP;
				end
			end
			S_TOP: begin
				cmd.op  = OP_TOP_RD;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (slot_free) begin
					cmd.op  = OP_FINISH;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.op == OP_FINISH)
				out_valid_q <= 1'b1;
			else if (rsp_ready)
				out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTH
	a_rise_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_FIN)
		else $error("result raised outside the finish state");
`endif

endmodule

`default_nettype wire

>>> rtl/core/hpq_dpath.sv
// ----------------------------------------------------------------------------
// hpq_dpath
// Heap memory, element count, hole position and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hpq_dpath
	import hpq_pkg::*;
#(
	parameter int CAPACITY = DEFAULT_CAPACITY
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire req_t req,
	input  wire cmd_t cmd,
	output stat_t     stat,
	output rsp_t      rsp
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW:0] CAP_W = (CW + 1)'(CAPACITY);

	logic signed [31:0] mem [CAPACITY];

	logic [CW-1:0]      n_q;
	logic [AW-1:0]      pos_q;
	logic signed [31:0] cur_q;
	logic               func_q;
	logic [1:0]         status_q;
	logic signed [31:0] popped_q;
	logic signed [31:0] rd0_q, rd1_q;
	rsp_t               out_q;

	// read / write port controls
	logic               rd_en;
	logic [AW-1:0]      ra0, ra1;
	logic               wr_en;
	logic [AW-1:0]      wa;
	logic signed [31:0] wd;

	// neighbor indices of the hole, one bit wider than the count
	logic [CW:0]        left_w, right_w, n_w;
	logic [AW-1:0]      parent;
	logic               right_ok;
	logic signed [31:0] best_val;
	logic [AW-1:0]      best_idx;
	logic [AW-1:0]      last_idx;
	logic [CW+8:0]      n_ext;

	assign n_w      = {1'b0, n_q};
	assign left_w   = {{(CW - AW){1'b0}}, pos_q, 1'b1};
	assign right_w  = left_w + (CW + 1)'(1);
	assign parent   = (pos_q - AW'(1)) >> 1;
	assign last_idx = AW'(n_q - CW'(1));
	assign right_ok = (right_w < n_w);
	// larger child, left one on a tie
	assign best_val = (right_ok && (rd1_q > rd0_q)) ? rd1_q : rd0_q;
	assign best_idx = (right_ok && (rd1_q > rd0_q)) ? AW'(right_w) : AW'(left_w);
	assign n_ext    = {9'd0, n_q};

	assign stat.is_pop   = func_q;
	assign stat.reject   = func_q ? (n_q == '0) : (n_w == CAP_W);
	assign stat.at_root  = (pos_q == '0);
	assign stat.has_left = (left_w < n_w);
	assign stat.swap     = func_q ? (best_val > cur_q) : (cur_q > rd0_q);

	assign rsp = out_q;

	always_comb begin
		rd_en = 1'b0;
		ra0   = '0;
		ra1   = '0;
		wr_en = 1'b0;
		wa    = pos_q;
		wd    = cur_q;
		case (cmd.op)
			OP_UP_RD: begin
				rd_en = 1'b1;
				ra0   = parent;
			end
			OP_POP_RD: begin
				rd_en = 1'b1;
				ra1   = last_idx;
			end
			OP_DN_RD: begin
				rd_en = 1'b1;
				ra0   = AW'(left_w);
				ra1   = AW'(right_w);
			end
			OP_TOP_RD: begin
				rd_en = 1'b1;
			end
			OP_PLACE: begin
				wr_en = 1'b1;
			end
			OP_UP_MOVE: begin
				wr_en = 1'b1;
				wd    = rd0_q;
			end
			OP_DN_MOVE: begin
				wr_en = 1'b1;
				wd    = best_val;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wa] <= wd;
		if (rd_en) begin
			rd0_q <= mem[ra0];
			rd1_q <= mem[ra1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
		end else if (cmd.op == OP_INC) begin
			n_q <= n_q + CW'(1);
		end else if (cmd.op == OP_POP_TAKE) begin
			n_q <= n_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				func_q   <= req.func;
				cur_q    <= req.value;
				pos_q    <= AW'(n_q);
				status_q <= ST_OK;
				popped_q <= '0;
			end
			OP_REJECT: begin
				status_q <= func_q ? ST_EMPTY : ST_FULL;
			end
			OP_UP_MOVE: begin
				pos_q <= parent;
			end
			OP_POP_TAKE: begin
				popped_q <= rd0_q;
				cur_q    <= rd1_q;
				pos_q    <= '0;
			end
			OP_DN_MOVE: begin
				pos_q <= best_idx;
			end
			OP_FINISH: begin
				out_q.status       <= status_q;
				out_q.popped_value <= popped_q;
				out_q.top_value    <= (n_q == '0) ? 32'sd0 : rd0_q;
				out_q.count        <= n_ext[8:0];
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_w <= CAP_W)
		else $error("element count above capacity");
	a_inc_only_below_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_INC |-> n_w < CAP_W)
		else $error("push admitted on full heap");
	a_dn_stays_inside: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_DN_MOVE |=> {{(CW + 1 - AW){1'b0}}, pos_q} < n_w)
		else $error("sift-down moved hole past the last element");
`endif

endmodule

`default_nettype wire

>>> rtl/core/max_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap priority queue: push a signed value or pop the maximum.
// ----------------------------------------------------------------------------
//
//   channel  handshake              payload  direction
//   req      req_valid / req_ready  req_t    in   (func, value)
//   rsp      rsp_valid / rsp_ready  rsp_t    out  (status, popped_value,
//                                                  top_value, count)
//
// One item at a time. A push checks the count, increments it and sifts up;
// a pop reads the root and the last element, returns the root and sifts the
// last one down. The element moves at most log2(CAPACITY) levels; each level
// is one registered memory read then one compare-and-write, and a compare can
// stop the walk early. Then the element is placed and the new top is read;
// rejected items skip to the top read.
// Reset clears the element count, sequencer state and result valid flag;
// heap memory is left as is. A finished result sits in the output register;
// the next item is accepted while it waits, and that item stalls in the
// finish state until the register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module max_heap_priority_queue
	import hpq_pkg::*;
#(
	parameter int CAPACITY = DEFAULT_CAPACITY
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	cmd_t  cmd;
	stat_t stat;

	// sequencer: walks sift-up / sift-down one level per read+compare pair
	hpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// heap store, count, moving element (hole method) and result register
	hpq_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for max_heap_priority_queue. A shadow heap in the bench
// predicts status, popped maximum, new top and count for every accepted item;
// results are checked in order against it. Directed edge cases come first,
// then a fill-to-capacity pass, an output back-pressure pass and long random
// push/pop phases with bursty requests and varied result stalls.
// ----------------------------------------------------------------------------

module tb_top;
	import hpq_pkg::*;

	localparam int CAP         = DEFAULT_CAPACITY;
	localparam int WDOG_LIMIT  = 4000; // cycles with no item moving while work is pending
	localparam int DRAIN_WAIT  = 40;   // wait after the last result, before the verdict
	localparam int MAX_REPORTS = 10;
	localparam int HOLD_CYCLES = 300;  // long result stall in the pressure test
	localparam int RANDOM_OPS  = 800;

	// how rsp_ready behaves outside a long hold
	typedef enum int {RX_ALWAYS, RX_COIN, RX_PATTERN, RX_SPARSE} rx_style_t;

	// how push keys are drawn
	typedef enum int {KEY_WIDE, KEY_NARROW, KEY_EDGE, KEY_MIXED} key_style_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// shadow copy of the heap, 0-based: children of p are 2p+1 and 2p+2
	logic signed [31:0] shadow_heap [CAP];
	int unsigned        shadow_count = 0;

	// results owed by the block, oldest first
	rsp_t pending_rsps [$];

	int        fail_count  = 0;
	int        stall_count = 0;
	rx_style_t rx_style    = RX_ALWAYS;
	int        hold_req    = 0;    // set by a test, picked up by the receiver
	bit        tx_bursty   = 1'b0;
	int        burst_left  = 0;

	max_heap_priority_queue #(
		.CAPACITY(CAP)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Shadow heap: applies one request and returns the result it must give.
	// Sift-up and sift-down only move past a strictly smaller key; on a tie
	// between children the left one wins.
	// ------------------------------------------------------------------------
	function automatic rsp_t predict_heap_op(req_t r);
		rsp_t               res;
		int unsigned        pos;
		int unsigned        parent;
		int unsigned        left;
		int unsigned        right;
		int unsigned        best;
		logic signed [31:0] tmp;
		bit                 settled;
		res        = '0;
		res.status = ST_OK;
		if (r.func == FUNC_PUSH) begin
			if (shadow_count >= CAP) begin
				res.status = ST_FULL;
			end else begin
				pos              = shadow_count;
				shadow_heap[pos] = r.value;
				shadow_count++;
				settled = 1'b0;
				while (pos > 0 && !settled) begin
					parent = (pos - 1) / 2;
					if (shadow_heap[pos] > shadow_heap[parent]) begin
						tmp                 = shadow_heap[pos];
						shadow_heap[pos]    = shadow_heap[parent];
						shadow_heap[parent] = tmp;
						pos                 = parent;
					end else begin
						settled = 1'b1;
					end
				end
			end
		end else if (shadow_count == 0) begin
			res.status = ST_EMPTY;
		end else begin
			res.popped_value = shadow_heap[0];
			shadow_count--;
			shadow_heap[0] = shadow_heap[shadow_count];
			pos     = 0;
			settled = 1'b0;
			while (!settled) begin
				left  = 2 * pos + 1;
				right = left + 1;
				best  = pos;
				if (left < shadow_count && shadow_heap[left] > shadow_heap[best])
					best = left;
				if (right < shadow_count && shadow_heap[right] > shadow_heap[best])
					best = right;
				if (best == pos) begin
					settled = 1'b1;
				end else begin
					tmp               = shadow_heap[pos];
					shadow_heap[pos]  = shadow_heap[best];
					shadow_heap[best] = tmp;
					pos               = best;
				end
			end
		end
		res.top_value = (shadow_count > 0) ? shadow_heap[0] : 32'sd0;
		res.count     = shadow_count[8:0];
		return res;
	endfunction

	function automatic logic signed [31:0] rand_key(key_style_t style);
		key_style_t         pick;
		logic signed [31:0] key;
		pick = (style == KEY_MIXED) ? key_style_t'($urandom_range(0, 2)) : style;
		case (pick)
			KEY_NARROW: key = $signed($urandom_range(0, 8)) - 4; // lots of ties
			KEY_EDGE: begin
				case ($urandom_range(0, 4))
					0:       key = 32'sh7fffffff;
					1:       key = 32'sh80000000;
					2:       key = 32'sd0;
					3:       key = -32'sd1;
					default: key = 32'sd1;
				endcase
			end
			default: key = $urandom;
		endcase
		return key;
	endfunction

	function automatic void note_failure(string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("[%0t] %s", $realtime, msg);
	endfunction

	// ------------------------------------------------------------------------
	// Request side. In bursty mode items go out in bursts; between bursts valid
	// may drop for a random gap. Valid stays up across back-to-back items, payload changes on
	// the falling edge after acceptance.
	// ------------------------------------------------------------------------
	task automatic send_op(input logic func, input logic signed [31:0] key);
		req_t item;
		int   gap;
		item.func  = func;
		item.value = key;
		if (tx_bursty && burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				req_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 10);
		end
		if (burst_left > 0)
			burst_left--;
		@(negedge clk);
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (!req_ready);
		pending_rsps.push_back(predict_heap_op(item));
	endtask

	// ------------------------------------------------------------------------
	// Result side. A hold request from a test wins over the current style
	// and keeps ready low for that many cycles, counted here.
	// ------------------------------------------------------------------------
	initial begin : rx_drive
		int hold_left;
		int tick;
		tick = 0;
		forever begin
			@(negedge clk);
			tick++;
			if (hold_req > 0) begin
				rsp_ready <= 1'b0;
				hold_left = hold_req;
				hold_req  = 0;
				while (hold_left > 1) begin
					@(negedge clk);
					hold_left--;
				end
			end else begin
				case (rx_style)
					RX_ALWAYS:  rsp_ready <= 1'b1;
					RX_COIN:    rsp_ready <= $urandom_range(0, 1);
					RX_PATTERN: rsp_ready <= (tick % 11) < 6; // drifts against op lengths
					default:    rsp_ready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	// in-order result check against the shadow heap
	always @(posedge clk) begin : rsp_check
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsps.size() == 0) begin
				note_failure($sformatf("unexpected item: status %0d popped %0d top %0d count %0d",
					rsp.status, rsp.popped_value, rsp.top_value, rsp.count));
			end else begin
				want = pending_rsps.pop_front();
				if (rsp.status !== want.status || rsp.popped_value !== want.popped_value ||
						rsp.top_value !== want.top_value || rsp.count !== want.count) begin
					note_failure($sformatf({"mismatch: exp status %0d popped %0d top %0d count %0d,",
						" got status %0d popped %0d top %0d count %0d"},
						want.status, want.popped_value, want.top_value, want.count,
						rsp.status, rsp.popped_value, rsp.top_value, rsp.count));
				end
			end
		end
	end

	// watchdog: only counts while something is offered or owed
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
				(!req_valid && pending_rsps.size() == 0)) begin
			stall_count = 0;
		end else begin
			stall_count++;
			if (stall_count >= WDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// empty pops, key extremes, equal keys, drain to empty and two more pops
	task automatic test_directed();
		rx_style  = RX_COIN;
		tx_bursty = 1'b1;
		send_op(FUNC_POP, 32'sd0);
		send_op(FUNC_POP, 32'sh7fffffff); // key on a pop is ignored
		send_op(FUNC_PUSH, 32'sh80000000);
		send_op(FUNC_PUSH, 32'sh7fffffff);
		send_op(FUNC_PUSH, 32'sd0);
		send_op(FUNC_PUSH, -32'sd1);
		send_op(FUNC_PUSH, 32'sd1);
		send_op(FUNC_PUSH, 32'sd7);
		send_op(FUNC_PUSH, 32'sd7);
		send_op(FUNC_PUSH, 32'sd7);
		send_op(FUNC_PUSH, 32'sh7fffffff); // ties with the root
		repeat (10) send_op(FUNC_POP, $urandom);
		send_op(FUNC_POP, $urandom);
	endtask

	// fill to capacity, push into a full heap, drain past empty
	task automatic test_full_heap();
		rx_style  = RX_PATTERN;
		tx_bursty = 1'b0;
		repeat (CAP) send_op(FUNC_PUSH, rand_key(KEY_MIXED));
		rx_style = RX_SPARSE;
		send_op(FUNC_PUSH, 32'sh7fffffff);
		send_op(FUNC_PUSH, 32'sh80000000);
		send_op(FUNC_PUSH, $urandom);
		rx_style  = RX_COIN;
		tx_bursty = 1'b1;
		repeat (CAP + 2) send_op(FUNC_POP, $urandom);
	endtask

	// results held off for a long stretch while requests keep coming,
	// so the output register fills and the request side stalls
	task automatic test_backpressure();
		rx_style  = RX_ALWAYS;
		tx_bursty = 1'b0;
		hold_req  = HOLD_CYCLES;
		repeat (6) send_op(FUNC_PUSH, rand_key(KEY_WIDE));
		hold_req = HOLD_CYCLES;
		repeat (6) send_op(FUNC_POP, $urandom);
	endtask

	// phases with a random push/pop balance, key style and idling style
	task automatic test_random_mix(input int n_ops);
		int         done;
		int         phase_len;
		int         push_pct;
		key_style_t keys;
		done = 0;
		while (done < n_ops) begin
			phase_len = $urandom_range(20, 120);
			push_pct  = 10 + 20 * $urandom_range(0, 4);
			keys      = key_style_t'($urandom_range(0, 3));
			rx_style  = rx_style_t'($urandom_range(0, 3));
			tx_bursty = ($urandom_range(0, 2) != 0);
			for (int i = 0; i < phase_len && done < n_ops; i++) begin
				if ($urandom_range(0, 99) < push_pct)
					send_op(FUNC_PUSH, rand_key(keys));
				else
					send_op(FUNC_POP, $urandom);
				done++;
			end
		end
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_full_heap();
		test_backpressure();
		test_random_mix(RANDOM_OPS);
		@(negedge clk);
		req_valid <= 1'b0;
		rx_style = RX_COIN;
		while (pending_rsps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
